/* hdl/rmis_pkg.sv */
package rmis_pkg;

   localparam int WINDOW_LEN = 10;
   localparam int IDX_W      = $clog2(WINDOW_LEN);
   localparam int MEDIAN_IDX = WINDOW_LEN / 2;

   localparam int SAMPLE_W = 15;
   localparam int SMOOTH_W = 23;
   localparam int COEF_W   = 16;
   localparam int PROD_W   = COEF_W + SMOOTH_W;
   localparam int ACC_W    = 42;
   localparam int FRAC_SH  = 14;
   localparam int IN_SH    = 8;
   localparam int YF_W     = ACC_W - FRAC_SH;

   localparam int Y_MAX      = 4194048;
   localparam int Y_MIN      = -4194048;
   localparam int ROUND_BIAS = 8192;

   localparam int APB_DW = 32;
   localparam int APB_AW = 4;

   localparam logic [1:0] REG_COEF_CURRENT_IN   = 2'd0;
   localparam logic [1:0] REG_COEF_PREVIOUS_IN  = 2'd1;
   localparam logic [1:0] REG_COEF_PREVIOUS_OUT = 2'd2;

   localparam logic signed [COEF_W-1:0] COEF_CURRENT_IN_RST   = 16'sd492;
   localparam logic signed [COEF_W-1:0] COEF_PREVIOUS_IN_RST  = 16'sd328;
   localparam logic signed [COEF_W-1:0] COEF_PREVIOUS_OUT_RST = 16'sd15565;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SHIFT,
      OP_PLACE,
      OP_MUL_CUR,
      OP_MUL_PREV_IN,
      OP_MUL_PREV_OUT,
      OP_SUM,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
      logic   dir_up;
   } cmd_type;

   typedef struct packed {
      logic carry_gt;
      logic carry_lt;
      logic at_top;
      logic at_bottom;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] current_in;
      logic signed [COEF_W-1:0] previous_in;
      logic signed [COEF_W-1:0] previous_out;
   } coef_type;

endpackage

/* hdl/rmis_csr.sv */
module rmis_csr
   import rmis_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready,
   output coef_type          coef
);

   coef_type   coef_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[APB_AW-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.current_in   <= COEF_CURRENT_IN_RST;
         coef_ff.previous_in  <= COEF_PREVIOUS_IN_RST;
         coef_ff.previous_out <= COEF_PREVIOUS_OUT_RST;
      end else if (wr_en) begin
         // writes past the last register are dropped
         unique case (reg_idx)
            REG_COEF_CURRENT_IN:   coef_ff.current_in   <= pwdata[COEF_W-1:0];
            REG_COEF_PREVIOUS_IN:  coef_ff.previous_in  <= pwdata[COEF_W-1:0];
            REG_COEF_PREVIOUS_OUT: coef_ff.previous_out <= pwdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_COEF_CURRENT_IN:   prdata = APB_DW'(coef_ff.current_in);
         REG_COEF_PREVIOUS_IN:  prdata = APB_DW'(coef_ff.previous_in);
         REG_COEF_PREVIOUS_OUT: prdata = APB_DW'(coef_ff.previous_out);
         default:               prdata = '0;
      endcase
   end

   assign coef = coef_ff;

endmodule

/* hdl/rmis_datapath.sv */
module rmis_datapath
   import rmis_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  coef_type                   coef,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] median_out,
   output logic signed [SMOOTH_W-1:0] smoothed_out,
   output logic                       saturated_out
);

   logic signed [SAMPLE_W-1:0] window_ff [WINDOW_LEN];
   logic [IDX_W-1:0]           pos_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic signed [SAMPLE_W-1:0] carry_ff;
   logic signed [SAMPLE_W-1:0] prev_median_ff;
   logic signed [SMOOTH_W-1:0] prev_out_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_median_ff;
   logic signed [SMOOTH_W-1:0] rsp_smooth_ff;
   logic                       rsp_sat_ff;

   logic signed [SAMPLE_W-1:0] rd_val;
   logic signed [SAMPLE_W-1:0] median;
   logic                       at_top;
   logic                       at_bottom;
   logic signed [COEF_W-1:0]   mul_coef;
   logic signed [SMOOTH_W-1:0] mul_opnd;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [ACC_W-1:0]    prod_ext;
   logic signed [YF_W-1:0]     y_full;
   logic signed [SMOOTH_W-1:0] y_sat;
   logic                       y_clip;

   assign at_top    = (idx_ff == IDX_W'(WINDOW_LEN - 1));
   assign at_bottom = (idx_ff == '0);
   assign median    = window_ff[MEDIAN_IDX];

   // single read port: the neighbor in the direction of the pass
   always_comb begin
      rd_val = '0;
      if (cmd.dir_up) begin
         if (!at_top) rd_val = window_ff[idx_ff + IDX_W'(1)];
      end else begin
         if (!at_bottom) rd_val = window_ff[idx_ff - IDX_W'(1)];
      end
   end

   assign status.carry_gt  = carry_ff > rd_val;
   assign status.carry_lt  = carry_ff < rd_val;
   assign status.at_top    = at_top;
   assign status.at_bottom = at_bottom;
   assign status.out_busy  = rsp_valid_ff && rsp_stall;

   // shared multiplier, operands chosen by the current step
   always_comb begin
      mul_coef = coef.previous_out;
      mul_opnd = prev_out_ff;
      unique case (cmd.op)
         OP_MUL_CUR: begin
            mul_coef = coef.current_in;
            mul_opnd = SMOOTH_W'(median);
         end
         OP_MUL_PREV_IN: begin
            mul_coef = coef.previous_in;
            mul_opnd = SMOOTH_W'(prev_median_ff);
         end
         default: begin
            mul_coef = coef.previous_out;
            mul_opnd = prev_out_ff;
         end
      endcase
   end

   assign prod_in  = PROD_W'(mul_coef) * PROD_W'(mul_opnd);
   assign prod_ext = ACC_W'(prod_ff);
   assign y_full   = acc_ff[ACC_W-1:FRAC_SH];

   always_comb begin
      y_clip = 1'b0;
      y_sat  = y_full[SMOOTH_W-1:0];
      if (y_full > YF_W'(Y_MAX)) begin
         y_clip = 1'b1;
         y_sat  = SMOOTH_W'(Y_MAX);
      end else if (y_full < YF_W'(Y_MIN)) begin
         y_clip = 1'b1;
         y_sat  = SMOOTH_W'(Y_MIN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) window_ff[i] <= '0;
         pos_ff         <= '0;
         idx_ff         <= '0;
         prev_median_ff <= '0;
         prev_out_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // present a new result, or drop valid once the transfer is done
         if (cmd.op == OP_FINISH) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (cmd.op)
            OP_LOAD: begin
               carry_ff <= sample;
               idx_ff   <= pos_ff;
            end
            OP_SHIFT: begin
               window_ff[idx_ff] <= rd_val;
               idx_ff <= cmd.dir_up ? idx_ff + IDX_W'(1) : idx_ff - IDX_W'(1);
            end
            OP_PLACE: window_ff[idx_ff] <= carry_ff;
            OP_MUL_CUR: prod_ff <= prod_in;
            OP_MUL_PREV_IN: begin
               prod_ff <= prod_in;
               acc_ff  <= (prod_ext <<< IN_SH) + ACC_W'(ROUND_BIAS);
            end
            OP_MUL_PREV_OUT: begin
               prod_ff <= prod_in;
               acc_ff  <= acc_ff + (prod_ext <<< IN_SH);
            end
            OP_SUM: acc_ff <= acc_ff + prod_ext;
            OP_FINISH: begin
               rsp_median_ff  <= median;
               rsp_smooth_ff  <= y_sat;
               rsp_sat_ff     <= y_clip;
               prev_median_ff <= median;
               prev_out_ff    <= y_sat;
               pos_ff <= (pos_ff == IDX_W'(WINDOW_LEN - 1)) ? '0 : pos_ff + IDX_W'(1);
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign median_out    = rsp_median_ff;
   assign smoothed_out  = rsp_smooth_ff;
   assign saturated_out = rsp_sat_ff;

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (idx_ff <= IDX_W'(WINDOW_LEN - 1)) && (pos_ff <= IDX_W'(WINDOW_LEN - 1)))
      else $error("window index out of range");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINISH) |=> rsp_valid_ff)
      else $error("finished item not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINISH) |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending result overwritten");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |->
         (rsp_smooth_ff == SMOOTH_W'(Y_MAX) || rsp_smooth_ff == SMOOTH_W'(Y_MIN)))
      else $error("clip flag without clipped value");
`endif

endmodule

/* hdl/rmis_ctrl.sv */
module rmis_ctrl
   import rmis_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHK_UP,
      S_CHK_DN,
      S_BUB_UP,
      S_BUB_DN,
      S_PLACE,
      S_MUL_CUR,
      S_MUL_PREV_IN,
      S_MUL_PREV_OUT,
      S_SUM,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;
   logic      req_stall_in;
   logic      accept;

   assign accept = req_valid && !req_stall_ff;

   always_comb begin
      state_in     = state_ff;
      req_stall_in = req_stall_ff;
      cmd.op       = OP_NONE;
      cmd.dir_up   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.op       = OP_LOAD;
               state_in     = S_CHK_UP;
               req_stall_in = 1'b1;
            end
         end
         S_CHK_UP: begin
            state_in = (!status.at_top && status.carry_gt) ? S_BUB_UP : S_CHK_DN;
         end
         S_CHK_DN: begin
            cmd.dir_up = 1'b0;
            state_in = (!status.at_bottom && status.carry_lt) ? S_BUB_DN : S_PLACE;
         end
         S_BUB_UP: begin
            if (!status.at_top && status.carry_gt) begin
               cmd.op = OP_SHIFT;
            end else begin
               cmd.op   = OP_PLACE;
               state_in = S_MUL_CUR;
            end
         end
         S_BUB_DN: begin
            cmd.dir_up = 1'b0;
            if (!status.at_bottom && status.carry_lt) begin
               cmd.op = OP_SHIFT;
            end else begin
               cmd.op   = OP_PLACE;
               state_in = S_MUL_CUR;
            end
         end
         S_PLACE: begin
            cmd.op   = OP_PLACE;
            state_in = S_MUL_CUR;
         end
         S_MUL_CUR: begin
            cmd.op   = OP_MUL_CUR;
            state_in = S_MUL_PREV_IN;
         end
         S_MUL_PREV_IN: begin
            cmd.op   = OP_MUL_PREV_IN;
            state_in = S_MUL_PREV_OUT;
         end
         S_MUL_PREV_OUT: begin
            cmd.op   = OP_MUL_PREV_OUT;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.op       = OP_FINISH;
               state_in     = S_IDLE;
               req_stall_in = 1'b0;
            end
         end
         default: begin
            state_in     = S_IDLE;
            req_stall_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
      end
   end

   assign req_stall = req_stall_ff;

`ifndef SYNTHESIS
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == S_IDLE))
      else $error("transfer taken while busy");
`endif

endmodule

/* hdl/running_median_iir_smoother.sv */
// Running median plus first-order IIR smoother for one sensor channel.
//
// Input channel req_*: one transfer carries a signed sample in tenths. The
// sample replaces the oldest slot of a sorted ten-entry window; one
// compare-and-move per cycle restores order, then the upper median feeds
// y = a*x + b*x_prev + c*y_prev through one shared 16x23 multiplier.
// Result channel rsp_*: one transfer per sample with the median, the
// rounded and saturated filter output (8 fractional bits) and a clip flag.
// The time from input transfer to rsp_valid is set by the length of the
// insertion pass (up to nine window moves) plus the multiply/accumulate
// steps; the next sample is taken the cycle after the result is loaded
// into the output register, so a new sample is never taken before the
// last one is done. req_stall stays high while an item is in flight.
// A stalled result is held in the output register; the next item runs up
// to its last step and then waits there until that register is free.
// Reset (synchronous, active high) clears the window, the filter history,
// the insert position and the output valid, and restores the default
// coefficients. Coefficients (Q2.14) are written through the APB port at
// byte addresses 0, 4 and 8; write them only while the block is idle.
module running_median_iir_smoother
   import rmis_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // input channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_tenths,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_median_tenths,
   output logic signed [SMOOTH_W-1:0] rsp_smoothed_value,
   output logic                       rsp_saturated_flag,
   // configuration port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [APB_AW-1:0]          paddr,
   input  logic [APB_DW-1:0]          pwdata,
   output logic [APB_DW-1:0]          prdata,
   output logic                       pready
);

   coef_type   coef;
   cmd_type    cmd;
   status_type status;

   // coefficient registers
   rmis_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef    (coef)
   );

   // sequencer: insertion pass, then multiply/accumulate steps
   rmis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // window, multiplier, accumulator and output register
   rmis_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .coef          (coef),
      .sample        (req_sample_tenths),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .median_out    (rsp_median_tenths),
      .smoothed_out  (rsp_smoothed_value),
      .saturated_out (rsp_saturated_flag)
   );

endmodule
